// ===== hw/rtl/tfmc_pkg.sv =====
`timescale 1ns / 1ps

package tfmc_pkg;

    // CORDIC iteration count and datapath widths
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int CW           = 40;
    localparam int ZW           = 24;
    localparam int DIV_W        = 36;
    localparam int DCNT_W       = $clog2(DIV_W);

    // Stream widths
    localparam int IN_W  = 192;
    localparam int OUT_W = 184;

    // Fixed-point constants
    localparam int PI_Q16       = 205887;
    localparam int HALF_PI_Q16  = 102944;
    localparam int INV_GAIN_Q30 = 652032875;
    localparam int ONE_Q28      = 268435456;

    // Flight modes
    localparam logic [1:0] MODE_SEARCH   = 2'd0;
    localparam logic [1:0] MODE_FOLLOW   = 2'd1;
    localparam logic [1:0] MODE_TAKEOVER = 2'd2;

    // Item kinds
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_DETECT = 2'd1;
    localparam logic [1:0] OP_LOST   = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;

    // Setpoint kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_HOLD    = 2'd1;
    localparam logic [1:0] KIND_FOLLOW  = 2'd2;
    localparam logic [1:0] KIND_SILENCE = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_DIST_GAIN   = 3'd0;
    localparam logic [2:0] REG_YAW_GAIN    = 3'd1;
    localparam logic [2:0] REG_IMG_MID     = 3'd2;
    localparam logic [2:0] REG_HEIGHT_GOAL = 3'd3;
    localparam logic [2:0] REG_LOSS_LIMIT  = 3'd4;
    localparam logic [2:0] REG_HOVER_SPIN  = 3'd5;
    localparam logic [2:0] REG_SEARCH_SPIN = 3'd6;

    // Command to the CORDIC unit
    typedef struct packed {
        logic start;
        logic vec_mode;
    } cordic_cmd_t;

    // atan(2^-i) in Q16.16, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        begin
            case (idx)
                5'd0:    v = ZW'(51472);
                5'd1:    v = ZW'(30386);
                5'd2:    v = ZW'(16055);
                5'd3:    v = ZW'(8150);
                5'd4:    v = ZW'(4091);
                5'd5:    v = ZW'(2047);
                5'd6:    v = ZW'(1024);
                5'd7:    v = ZW'(512);
                5'd8:    v = ZW'(256);
                5'd9:    v = ZW'(128);
                5'd10:   v = ZW'(64);
                5'd11:   v = ZW'(32);
                5'd12:   v = ZW'(16);
                5'd13:   v = ZW'(8);
                5'd14:   v = ZW'(4);
                5'd15:   v = ZW'(2);
                5'd16:   v = ZW'(1);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== hw/rtl/tfmc_div.sv =====
`timescale 1ns / 1ps

module tfmc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tfmc_pkg::DIV_W-1:0] dividend,
    input  logic [11:0]               divisor,
    output logic                      done,
    output logic [tfmc_pkg::DIV_W-1:0] quotient
);
    import tfmc_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [11:0]       dvs_reg;
    logic [11:0]       rem_reg;
    logic [DIV_W-1:0]  quo_reg;

    logic [12:0]       shifted;
    logic [13:0]       diff;
    logic              ge;
    logic [11:0]       rem_next;
    logic [DIV_W-1:0]  quo_next;

    // One restoring step: bring down the next dividend bit
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIV_W-1]};
        diff     = {1'b0, shifted} - {2'b00, dvs_reg};
        ge       = !diff[13];
        rem_next = ge ? diff[11:0] : shifted[11:0];
        quo_next = {quo_reg[DIV_W-2:0], ge};
    end

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/tfmc_cordic.sv =====
`timescale 1ns / 1ps

module tfmc_cordic (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tfmc_pkg::cordic_cmd_t            cmd,
    input  logic signed [tfmc_pkg::CW-1:0]   x_in,
    input  logic signed [tfmc_pkg::CW-1:0]   y_in,
    input  logic signed [tfmc_pkg::ZW-1:0]   z_in,
    output logic                             done,
    output logic signed [tfmc_pkg::CW-1:0]   x_out,
    output logic signed [tfmc_pkg::CW-1:0]   y_out,
    output logic signed [tfmc_pkg::ZW-1:0]   z_out
);
    import tfmc_pkg::*;

    localparam logic signed [ZW-1:0] PI_Z      = ZW'(PI_Q16);
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(HALF_PI_Q16);
    localparam logic signed [CW-1:0] INV_GAIN  = CW'(INV_GAIN_Q30);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic              vec_reg;
    logic              flip_reg;
    logic              zero_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] at;
    logic                 up;

    // One micro-rotation, shared by vectoring and rotation
    always_comb
    begin
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        at = atan_q16(5'(step_reg));
        up = vec_reg ? !y_reg[CW-1] : z_reg[ZW-1];
    end

    // Sequence the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Fold the start vector or angle into range, then iterate
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            vec_reg <= cmd.vec_mode;
            if (cmd.vec_mode)
            begin
                flip_reg <= 1'b0;
                zero_reg <= (x_in == '0) && (y_in == '0);
                if (x_in[CW-1])
                begin
                    x_reg <= -x_in;
                    y_reg <= -y_in;
                    z_reg <= y_in[CW-1] ? -PI_Z : PI_Z;
                end
                else
                begin
                    x_reg <= x_in;
                    y_reg <= y_in;
                    z_reg <= '0;
                end
            end
            else
            begin
                zero_reg <= 1'b0;
                x_reg    <= INV_GAIN;
                y_reg    <= '0;
                if (z_in > HALF_PI_Z)
                begin
                    z_reg    <= z_in - PI_Z;
                    flip_reg <= 1'b1;
                end
                else if (z_in < -HALF_PI_Z)
                begin
                    z_reg    <= z_in + PI_Z;
                    flip_reg <= 1'b1;
                end
                else
                begin
                    z_reg    <= z_in;
                    flip_reg <= 1'b0;
                end
            end
        end
        else if (busy_reg)
        begin
            x_reg <= up ? x_reg + dx : x_reg - dx;
            y_reg <= up ? y_reg - dy : y_reg + dy;
            z_reg <= up ? z_reg + at : z_reg - at;
        end
    end

    assign done  = done_reg;
    assign x_out = flip_reg ? -x_reg : x_reg;
    assign y_out = flip_reg ? -y_reg : y_reg;
    assign z_out = zero_reg ? '0 : z_reg;

endmodule

// ===== hw/rtl/target_follow_mode_controller.sv =====
`timescale 1ns / 1ps
// A tick, a lost detection or a detection outside follow mode has its result registered
// as the item is accepted. A detection in follow mode runs the multiplier steps, the speed
// and spin divisions, a CORDIC vectoring pass and a rotation pass and the velocity steps,
// then posts its result once the output register is free.
// Throughput: one item at a time; next taken once the result is registered and output is free.
// Reset: asynchronous, active low; mode, counters and held position clear, registers load defaults.

module target_follow_mode_controller (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [4:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // position_valid, north_pos, east_pos, down_pos, quat_w, quat_x, quat_y, quat_z,
    // offboard_enabled, target_ctr_x, target_height, zero fill
    input  logic [tfmc_pkg::IN_W-1:0]   s_axis_tdata,
    // op
    input  logic [1:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // heartbeat, hold_north, hold_east, hold_down, vel_north, vel_east, spin_rate,
    // mode, zero fill
    output logic [tfmc_pkg::OUT_W-1:0]  m_axis_tdata,
    // setpoint_kind
    output logic [1:0]                  m_axis_tuser
);
    import tfmc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV_SPD,
        S_DIV_SPIN,
        S_VEC,
        S_ROT,
        S_VEL,
        S_DONE
    } state_t;

    localparam logic signed [CW-1:0] ONE_C = CW'(ONE_Q28);

    // Configuration registers
    logic [15:0]        dist_gain_reg;
    logic [15:0]        yaw_gain_reg;
    logic [11:0]        img_mid_reg;
    logic [11:0]        height_goal_reg;
    logic [15:0]        loss_limit_reg;
    logic signed [15:0] hover_spin_reg;
    logic signed [15:0] search_spin_reg;

    // Control state
    state_t             state_reg;
    logic [3:0]         mcnt_reg;
    logic               div_start_reg;
    logic               cor_start_reg;
    logic [1:0]         mode_reg;
    logic               target_seen_reg;
    logic [15:0]        miss_reg;
    logic signed [31:0] held_north_reg;
    logic signed [31:0] held_east_reg;
    logic signed [31:0] held_down_reg;
    logic               captured_reg;
    logic               takeover_reg;
    logic               stopped_reg;
    logic               out_valid_reg;

    // Follow datapath
    logic signed [15:0] lat_qw_reg;
    logic signed [15:0] lat_qx_reg;
    logic signed [15:0] lat_qy_reg;
    logic signed [15:0] lat_qz_reg;
    logic [11:0]        lat_tcx_reg;
    logic [11:0]        lat_th_reg;
    logic signed [63:0] mul_p_reg;
    logic signed [32:0] acc_a_reg;
    logic signed [32:0] acc_b_reg;
    logic signed [29:0] nspd_reg;
    logic signed [29:0] nspin_reg;
    logic signed [31:0] spd_reg;
    logic signed [15:0] spin_res_reg;
    logic signed [ZW-1:0] yaw_reg;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] vn_reg;

    // Result register
    logic               out_hb_reg;
    logic [1:0]         out_kind_reg;
    logic signed [31:0] out_hn_reg;
    logic signed [31:0] out_he_reg;
    logic signed [31:0] out_hd_reg;
    logic signed [31:0] out_vn_reg;
    logic signed [31:0] out_ve_reg;
    logic signed [15:0] out_spin_reg;
    logic [1:0]         out_mode_reg;

    // Input fields
    logic [1:0]         in_op;
    logic               in_pv;
    logic signed [31:0] in_north;
    logic signed [31:0] in_east;
    logic signed [31:0] in_down;
    logic signed [15:0] in_qw;
    logic signed [15:0] in_qx;
    logic signed [15:0] in_qy;
    logic signed [15:0] in_qz;
    logic               in_offboard;
    logic [11:0]        in_tcx;
    logic [11:0]        in_th;

    // Short-path next state and result
    logic [1:0]         mode_next;
    logic               target_seen_next;
    logic [15:0]        miss_next;
    logic signed [31:0] held_north_next;
    logic signed [31:0] held_east_next;
    logic signed [31:0] held_down_next;
    logic               captured_next;
    logic               takeover_next;
    logic               stopped_next;
    logic               r_hb;
    logic [1:0]         r_kind;
    logic signed [31:0] r_hn;
    logic signed [31:0] r_he;
    logic signed [31:0] r_hd;
    logic signed [15:0] r_spin;
    logic               long_go;

    logic               in_fire;
    logic               out_free;
    logic               cfg_wr;
    logic [11:0]        goal_eff;
    logic [11:0]        cx_eff;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_prod;
    logic [29:0]        mag_spd;
    logic [29:0]        mag_spin;
    logic [DIV_W-1:0]   div_dividend;
    logic [11:0]        div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;
    logic signed [31:0] spd_sat;
    logic signed [15:0] spin_sat;
    cordic_cmd_t        cor_cmd;
    logic signed [CW-1:0] cor_x_in;
    logic signed [CW-1:0] cor_y_in;
    logic               cor_done;
    logic signed [CW-1:0] cor_x_out;
    logic signed [CW-1:0] cor_y_out;
    logic signed [ZW-1:0] cor_z_out;

    // Shift a product down by 30 and clamp to 32 bits
    function automatic logic signed [31:0] sat_vel(input logic signed [63:0] p);
        logic signed [33:0] sh;
        begin
            sh = p[63:30];
            if (sh > 34'sh0_7FFF_FFFF)
                return 32'sh7FFF_FFFF;
            else if (sh < -34'sh0_8000_0000)
                return 32'sh8000_0000;
            else
                return sh[31:0];
        end
    endfunction

    // Unpack the input item
    assign in_op       = s_axis_tuser;
    assign in_pv       = s_axis_tdata[0];
    assign in_north    = s_axis_tdata[32:1];
    assign in_east     = s_axis_tdata[64:33];
    assign in_down     = s_axis_tdata[96:65];
    assign in_qw       = s_axis_tdata[112:97];
    assign in_qx       = s_axis_tdata[128:113];
    assign in_qy       = s_axis_tdata[144:129];
    assign in_qz       = s_axis_tdata[160:145];
    assign in_offboard = s_axis_tdata[161];
    assign in_tcx      = s_axis_tdata[173:162];
    assign in_th       = s_axis_tdata[185:174];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign pready        = 1'b1;

    // Read back configuration
    always_comb
    begin
        unique case (paddr[4:2])
            REG_DIST_GAIN:   prdata = {16'd0, dist_gain_reg};
            REG_YAW_GAIN:    prdata = {16'd0, yaw_gain_reg};
            REG_IMG_MID:     prdata = {20'd0, img_mid_reg};
            REG_HEIGHT_GOAL: prdata = {20'd0, height_goal_reg};
            REG_LOSS_LIMIT:  prdata = {16'd0, loss_limit_reg};
            REG_HOVER_SPIN:  prdata = {16'd0, hover_spin_reg};
            REG_SEARCH_SPIN: prdata = {16'd0, search_spin_reg};
            default:         prdata = '0;
        endcase
    end

    // Decide the short-path items and the mode updates
    always_comb
    begin
        mode_next        = mode_reg;
        target_seen_next = target_seen_reg;
        miss_next        = miss_reg;
        held_north_next  = held_north_reg;
        held_east_next   = held_east_reg;
        held_down_next   = held_down_reg;
        captured_next    = captured_reg;
        takeover_next    = takeover_reg;
        stopped_next     = stopped_reg;
        r_hb             = 1'b0;
        r_kind           = KIND_NONE;
        r_hn             = '0;
        r_he             = '0;
        r_hd             = '0;
        r_spin           = '0;
        long_go          = 1'b0;
        unique case (in_op)
            OP_TICK:
            begin
                if (mode_reg != MODE_TAKEOVER && !in_offboard && !takeover_reg)
                begin
                    takeover_next = 1'b1;
                    mode_next     = MODE_TAKEOVER;
                end
                r_hb = !stopped_reg;
                case (mode_next)
                    MODE_SEARCH:
                    begin
                        if (!stopped_reg)
                        begin
                            if (!captured_reg && in_pv)
                            begin
                                held_north_next = in_north;
                                held_east_next  = in_east;
                                held_down_next  = in_down;
                                captured_next   = 1'b1;
                            end
                            if (target_seen_reg)
                            begin
                                held_north_next = in_north;
                                held_east_next  = in_east;
                                held_down_next  = in_down;
                                mode_next       = MODE_FOLLOW;
                            end
                            else
                            begin
                                r_kind = KIND_HOLD;
                                r_spin = search_spin_reg;
                            end
                        end
                    end
                    MODE_FOLLOW:
                    begin
                        if (!target_seen_reg)
                        begin
                            held_north_next = in_north;
                            held_east_next  = in_east;
                            held_down_next  = in_down;
                            if (miss_reg < loss_limit_reg)
                            begin
                                if (!stopped_reg)
                                begin
                                    r_kind = KIND_HOLD;
                                    r_spin = hover_spin_reg;
                                end
                            end
                            else
                            begin
                                mode_next = MODE_SEARCH;
                            end
                        end
                    end
                    default:
                    begin
                        if (!stopped_reg)
                        begin
                            r_kind       = KIND_SILENCE;
                            stopped_next = 1'b1;
                        end
                    end
                endcase
                if (r_kind == KIND_HOLD)
                begin
                    r_hn = held_north_next;
                    r_he = held_east_next;
                    r_hd = held_down_next;
                end
            end
            OP_DETECT:
            begin
                target_seen_next = 1'b1;
                miss_next        = '0;
                long_go          = (mode_reg == MODE_FOLLOW) && !stopped_reg;
            end
            OP_LOST:
            begin
                target_seen_next = 1'b0;
                if (miss_reg != 16'hFFFF)
                    miss_next = miss_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Select multiplier operands by step
    always_comb
    begin
        goal_eff = (height_goal_reg == '0) ? 12'd1 : height_goal_reg;
        cx_eff   = (img_mid_reg == '0) ? 12'd1 : img_mid_reg;
        case (mcnt_reg)
            4'd0:
            begin
                mul_a = 32'(lat_qw_reg);
                mul_b = 32'(lat_qz_reg);
            end
            4'd1:
            begin
                mul_a = 32'(lat_qx_reg);
                mul_b = 32'(lat_qy_reg);
            end
            4'd2:
            begin
                mul_a = 32'(lat_qy_reg);
                mul_b = 32'(lat_qy_reg);
            end
            4'd3:
            begin
                mul_a = 32'(lat_qz_reg);
                mul_b = 32'(lat_qz_reg);
            end
            4'd4:
            begin
                mul_a = $signed({16'd0, dist_gain_reg});
                mul_b = 32'($signed({1'b0, goal_eff}) - $signed({1'b0, lat_th_reg}));
            end
            4'd5:
            begin
                mul_a = $signed({16'd0, yaw_gain_reg});
                mul_b = 32'($signed({1'b0, lat_tcx_reg}) - $signed({1'b0, cx_eff}));
            end
            4'd6:
            begin
                mul_a = spd_reg;
                mul_b = cos_reg;
            end
            4'd7:
            begin
                mul_a = spd_reg;
                mul_b = sin_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // Feed the divider with magnitudes of the scaled numerators
    always_comb
    begin
        mag_spd  = nspd_reg[29] ? 30'(-nspd_reg) : 30'(nspd_reg);
        mag_spin = nspin_reg[29] ? 30'(-nspin_reg) : 30'(nspin_reg);
        if (state_reg == S_DIV_SPIN)
        begin
            div_dividend = DIV_W'(mag_spin) << 4;
            div_divisor  = cx_eff;
        end
        else
        begin
            div_dividend = DIV_W'(mag_spd) << 8;
            div_divisor  = goal_eff;
        end
    end

    // Restore signs and clamp the quotients
    always_comb
    begin
        if (!nspd_reg[29])
            spd_sat = (div_q > DIV_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                       : $signed(div_q[31:0]);
        else
            spd_sat = (div_q > DIV_W'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000
                                                              : -$signed(div_q[31:0]);
        if (!nspin_reg[29])
            spin_sat = (div_q > DIV_W'(16'h7FFF)) ? 16'sh7FFF : $signed(div_q[15:0]);
        else
            spin_sat = (div_q > DIV_W'(17'h0_8000)) ? 16'sh8000 : -$signed(div_q[15:0]);
    end

    // Drive the CORDIC: vectoring on the attitude, rotation on the yaw
    assign cor_cmd.start    = cor_start_reg;
    assign cor_cmd.vec_mode = (state_reg == S_VEC);
    assign cor_x_in         = ONE_C - (CW'(acc_b_reg) <<< 1);
    assign cor_y_in         = CW'(acc_a_reg) <<< 1;

    tfmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    tfmc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cor_cmd),
        .x_in  (cor_x_in),
        .y_in  (cor_y_in),
        .z_in  (yaw_reg),
        .done  (cor_done),
        .x_out (cor_x_out),
        .y_out (cor_y_out),
        .z_out (cor_z_out)
    );

    // Sequencer, mode state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mcnt_reg        <= '0;
            div_start_reg   <= 1'b0;
            cor_start_reg   <= 1'b0;
            mode_reg        <= MODE_SEARCH;
            target_seen_reg <= 1'b0;
            miss_reg        <= '0;
            held_north_reg  <= '0;
            held_east_reg   <= '0;
            held_down_reg   <= '0;
            captured_reg    <= 1'b0;
            takeover_reg    <= 1'b0;
            stopped_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            dist_gain_reg   <= 16'd256;
            yaw_gain_reg    <= 16'd256;
            img_mid_reg     <= 12'd320;
            height_goal_reg <= 12'd100;
            loss_limit_reg  <= 16'd20;
            hover_spin_reg  <= 16'sd0;
            search_spin_reg <= 16'sd2048;
        end
        else
        begin
            div_start_reg <= 1'b0;
            cor_start_reg <= 1'b0;

            if (cfg_wr)
            begin
                unique case (paddr[4:2])
                    REG_DIST_GAIN:   dist_gain_reg   <= pwdata[15:0];
                    REG_YAW_GAIN:    yaw_gain_reg    <= pwdata[15:0];
                    REG_IMG_MID:     img_mid_reg     <= pwdata[11:0];
                    REG_HEIGHT_GOAL: height_goal_reg <= pwdata[11:0];
                    REG_LOSS_LIMIT:  loss_limit_reg  <= pwdata[15:0];
                    REG_HOVER_SPIN:  hover_spin_reg  <= pwdata[15:0];
                    REG_SEARCH_SPIN: search_spin_reg <= pwdata[15:0];
                    default:
                    begin
                    end
                endcase
            end

            // Drop the result once taken, load a new one when ready
            if (m_axis_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        mode_reg        <= mode_next;
                        target_seen_reg <= target_seen_next;
                        miss_reg        <= miss_next;
                        held_north_reg  <= held_north_next;
                        held_east_reg   <= held_east_next;
                        held_down_reg   <= held_down_next;
                        captured_reg    <= captured_next;
                        takeover_reg    <= takeover_next;
                        stopped_reg     <= stopped_next;
                        if (long_go)
                        begin
                            state_reg <= S_MUL;
                            mcnt_reg  <= '0;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                S_MUL:
                begin
                    mcnt_reg <= mcnt_reg + 1'b1;
                    if (mcnt_reg == 4'd6)
                    begin
                        state_reg     <= S_DIV_SPD;
                        div_start_reg <= 1'b1;
                    end
                end
                S_DIV_SPD:
                begin
                    if (div_done)
                    begin
                        state_reg     <= S_DIV_SPIN;
                        div_start_reg <= 1'b1;
                    end
                end
                S_DIV_SPIN:
                begin
                    if (div_done)
                    begin
                        state_reg     <= S_VEC;
                        cor_start_reg <= 1'b1;
                    end
                end
                S_VEC:
                begin
                    if (cor_done)
                    begin
                        state_reg     <= S_ROT;
                        cor_start_reg <= 1'b1;
                    end
                end
                S_ROT:
                begin
                    if (cor_done)
                    begin
                        state_reg <= S_VEL;
                        mcnt_reg  <= 4'd6;
                    end
                end
                S_VEL:
                begin
                    mcnt_reg <= mcnt_reg + 1'b1;
                    if (mcnt_reg == 4'd8)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Follow datapath and result payload
    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_prod;

        // Latch the detection fields
        if (in_fire)
        begin
            lat_qw_reg  <= in_qw;
            lat_qx_reg  <= in_qx;
            lat_qy_reg  <= in_qy;
            lat_qz_reg  <= in_qz;
            lat_tcx_reg <= in_tcx;
            lat_th_reg  <= in_th;
        end

        // Collect products in the cycle after their issue
        if (state_reg == S_MUL)
        begin
            case (mcnt_reg)
                4'd1:    acc_a_reg <= 33'(mul_p_reg);
                4'd2:    acc_a_reg <= acc_a_reg + 33'(mul_p_reg);
                4'd3:    acc_b_reg <= 33'(mul_p_reg);
                4'd4:    acc_b_reg <= acc_b_reg + 33'(mul_p_reg);
                4'd5:    nspd_reg  <= 30'(mul_p_reg);
                4'd6:    nspin_reg <= 30'(mul_p_reg);
                default:
                begin
                end
            endcase
        end

        if (state_reg == S_DIV_SPD && div_done)
            spd_reg <= spd_sat;
        if (state_reg == S_DIV_SPIN && div_done)
            spin_res_reg <= spin_sat;
        if (state_reg == S_VEC && cor_done)
            yaw_reg <= cor_z_out;
        if (state_reg == S_ROT && cor_done)
        begin
            cos_reg <= 32'(cor_x_out);
            sin_reg <= 32'(cor_y_out);
        end
        if (state_reg == S_VEL && mcnt_reg == 4'd7)
            vn_reg <= sat_vel(mul_p_reg);

        // Load the result register
        if (in_fire && !long_go)
        begin
            out_hb_reg   <= r_hb;
            out_kind_reg <= r_kind;
            out_hn_reg   <= r_hn;
            out_he_reg   <= r_he;
            out_hd_reg   <= r_hd;
            out_vn_reg   <= '0;
            out_ve_reg   <= '0;
            out_spin_reg <= r_spin;
            out_mode_reg <= mode_next;
        end
        else if (state_reg == S_VEL && mcnt_reg == 4'd8)
        begin
            out_hb_reg   <= 1'b0;
            out_kind_reg <= KIND_FOLLOW;
            out_hn_reg   <= '0;
            out_he_reg   <= '0;
            out_hd_reg   <= held_down_reg;
            out_vn_reg   <= vn_reg;
            out_ve_reg   <= sat_vel(mul_p_reg);
            out_spin_reg <= spin_res_reg;
            out_mode_reg <= mode_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {5'd0, out_mode_reg, out_spin_reg, out_ve_reg, out_vn_reg,
                            out_hd_reg, out_he_reg, out_hn_reg, out_hb_reg};

`ifndef SYNTHESIS
    a_takeover_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_TAKEOVER |=> mode_reg == MODE_TAKEOVER)
        else $error("takeover mode left");

    a_stopped_in_takeover: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> mode_reg == MODE_TAKEOVER)
        else $error("output stopped outside takeover");

    a_follow_result_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_FOLLOW |-> out_mode_reg == MODE_FOLLOW)
        else $error("follow setpoint outside follow mode");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV_SPD || state_reg == S_DIV_SPIN)
        else $error("divider finished outside a division step");
`endif

endmodule

// ===== tb/sv/target_follow_mode_controller_tb.sv =====
`timescale 1ns / 1ps

module target_follow_mode_controller_tb;
    import tfmc_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;
    localparam longint ATAN_Q16 [0:23] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
        512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

    typedef struct {
        logic [1:0]         op;
        logic               pos_valid;
        logic signed [31:0] north;
        logic signed [31:0] east;
        logic signed [31:0] down;
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic               offboard;
        logic [11:0]        box_x;
        logic [11:0]        box_h;
    } sample_t;

    typedef struct {
        logic               heartbeat;
        logic [1:0]         kind;
        logic signed [31:0] hold_n;
        logic signed [31:0] hold_e;
        logic signed [31:0] hold_d;
        logic signed [31:0] vel_n;
        logic signed [31:0] vel_e;
        logic signed [15:0] spin;
        logic [1:0]         mode;
    } setpoint_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [4:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    // position_valid, north_pos, east_pos, down_pos, quat_w, quat_x, quat_y, quat_z,
    // offboard_enabled, target_ctr_x, target_height, zero fill
    logic [IN_W-1:0]   s_axis_tdata;
    // op
    logic [1:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    // heartbeat, hold_north, hold_east, hold_down, vel_north, vel_east, spin_rate,
    // mode, zero fill
    logic [OUT_W-1:0]  m_axis_tdata;
    // setpoint_kind
    logic [1:0]        m_axis_tuser;

    // Controller shadow state
    logic [15:0]        dist_gain;
    logic [15:0]        yaw_gain;
    logic [11:0]        img_mid;
    logic [11:0]        height_goal;
    logic [15:0]        loss_limit;
    logic signed [15:0] hover_spin;
    logic signed [15:0] search_spin;
    logic [1:0]         flight_mode;
    logic               target_seen;
    logic [15:0]        miss_count;
    logic signed [31:0] held_n;
    logic signed [31:0] held_e;
    logic signed [31:0] held_d;
    logic               pos_captured;
    logic               takeover_seen;
    logic               output_stopped;

    setpoint_t pending_setpoints[$];
    int        mismatches;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_request;
    int        hold_left;
    int        quiet_cycles;

    target_follow_mode_controller uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Yaw from the vector (b, a) by CORDIC vectoring, Q16.16
    function automatic longint yaw_of(input longint a, input longint b);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = b;
        y = a;
        z = 0;
        if (a == 0 && b == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_Q16 : -PI_Q16;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += ATAN_Q16[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= ATAN_Q16[i];
            end
        end
        return z;
    endfunction

    // Cosine and sine of a Q16.16 angle, Q30, by CORDIC rotation
    task automatic rotate_unit(input longint ang, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        x = INV_GAIN_Q30;
        y = 0;
        z = ang;
        flip = 1'b0;
        if (z > HALF_PI_Q16)
        begin
            z -= PI_Q16;
            flip = 1'b1;
        end
        else if (z < -HALF_PI_Q16)
        begin
            z += PI_Q16;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ATAN_Q16[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ATAN_Q16[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic capture_position(input sample_t it);
        held_n = it.north;
        held_e = it.east;
        held_d = it.down;
    endtask

    // Advance the controller state by one item and give the setpoint it produces
    task automatic follow_step(input sample_t it, output setpoint_t r);
        longint goal;
        longint cx;
        longint spd;
        longint yaw;
        longint c;
        longint s;
        longint qw;
        longint qx;
        longint qy;
        longint qz;
        r = '{default: '0};
        if (it.op == OP_TICK)
        begin
            if (flight_mode != MODE_TAKEOVER && !it.offboard && !takeover_seen)
            begin
                takeover_seen = 1'b1;
                flight_mode = MODE_TAKEOVER;
            end
            r.heartbeat = !output_stopped;
            if (flight_mode == MODE_SEARCH)
            begin
                if (!output_stopped)
                begin
                    if (!pos_captured && it.pos_valid)
                    begin
                        capture_position(it);
                        pos_captured = 1'b1;
                    end
                    if (target_seen)
                    begin
                        capture_position(it);
                        flight_mode = MODE_FOLLOW;
                    end
                    else
                    begin
                        r.kind = KIND_HOLD;
                        r.spin = search_spin;
                    end
                end
            end
            else if (flight_mode == MODE_FOLLOW)
            begin
                if (!target_seen)
                begin
                    capture_position(it);
                    if (miss_count < loss_limit)
                    begin
                        if (!output_stopped)
                        begin
                            r.kind = KIND_HOLD;
                            r.spin = hover_spin;
                        end
                    end
                    else
                        flight_mode = MODE_SEARCH;
                end
            end
            else if (!output_stopped)
            begin
                r.kind = KIND_SILENCE;
                output_stopped = 1'b1;
            end
            if (r.kind == KIND_HOLD)
            begin
                r.hold_n = held_n;
                r.hold_e = held_e;
                r.hold_d = held_d;
            end
        end
        else if (it.op == OP_DETECT)
        begin
            target_seen = 1'b1;
            miss_count = '0;
            if (flight_mode == MODE_FOLLOW && !output_stopped)
            begin
                goal = (height_goal == 0) ? 1 : height_goal;
                cx = (img_mid == 0) ? 1 : img_mid;
                spd = longint'(dist_gain) * (goal - longint'(it.box_h)) * 256 / goal;
                spd = clamp(spd, -64'sd2147483648, 64'sd2147483647);
                r.spin = 16'(clamp(longint'(yaw_gain) * (longint'(it.box_x) - cx) * 16 / cx,
                    -32768, 32767));
                qw = it.qw;
                qx = it.qx;
                qy = it.qy;
                qz = it.qz;
                yaw = yaw_of(2 * (qw * qz + qx * qy), ONE_Q28 - 2 * (qy * qy + qz * qz));
                rotate_unit(yaw, c, s);
                r.vel_n = 32'(clamp((spd * c) >>> 30, -64'sd2147483648, 64'sd2147483647));
                r.vel_e = 32'(clamp((spd * s) >>> 30, -64'sd2147483648, 64'sd2147483647));
                r.hold_d = held_d;
                r.kind = KIND_FOLLOW;
            end
        end
        else if (it.op == OP_LOST)
        begin
            target_seen = 1'b0;
            if (miss_count != 16'hFFFF)
                miss_count++;
        end
        r.mode = flight_mode;
    endtask

    function automatic sample_t make_item(input logic [1:0] op, input logic offboard);
        sample_t it;
        it.op = op;
        it.pos_valid = ($urandom_range(0, 7) != 0);
        it.north = $urandom();
        it.east = $urandom();
        it.down = $urandom();
        it.qw = 16'($urandom_range(0, 32768) - 16384);
        it.qx = 16'($urandom_range(0, 32768) - 16384);
        it.qy = 16'($urandom_range(0, 32768) - 16384);
        it.qz = 16'($urandom_range(0, 32768) - 16384);
        it.offboard = offboard;
        it.box_x = 12'($urandom());
        it.box_h = 12'($urandom());
        return it;
    endfunction

    // Offer one item, predict its setpoint once it is taken
    task automatic send_item(input sample_t it);
        setpoint_t r;
        s_axis_tdata <= {6'd0, it.box_h, it.box_x, it.offboard, it.qz, it.qy, it.qx, it.qw,
            it.down, it.east, it.north, it.pos_valid};
        s_axis_tuser <= it.op;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        follow_step(it, r);
        pending_setpoints.push_back(r);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_setpoints.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DIST_GAIN:   dist_gain = value[15:0];
            REG_YAW_GAIN:    yaw_gain = value[15:0];
            REG_IMG_MID:     img_mid = value[11:0];
            REG_HEIGHT_GOAL: height_goal = value[11:0];
            REG_LOSS_LIMIT:  loss_limit = value[15:0];
            REG_HOVER_SPIN:  hover_spin = value[15:0];
            REG_SEARCH_SPIN: search_spin = value[15:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic load_settings(input int dg, input int yg, input int cx, input int goal,
                                 input int lim, input int hover, input int search);
        drain();
        write_reg(REG_DIST_GAIN, dg);
        write_reg(REG_YAW_GAIN, yg);
        write_reg(REG_IMG_MID, cx);
        write_reg(REG_HEIGHT_GOAL, goal);
        write_reg(REG_LOSS_LIMIT, lim);
        write_reg(REG_HOVER_SPIN, hover);
        write_reg(REG_SEARCH_SPIN, search);
    endtask

    task automatic send_detect(input int bx, input int bh, input int qw, input int qx,
                               input int qy, input int qz);
        sample_t it;
        it = make_item(OP_DETECT, 1'b1);
        it.box_x = 12'(bx);
        it.box_h = 12'(bh);
        it.qw = 16'(qw);
        it.qx = 16'(qx);
        it.qy = 16'(qy);
        it.qz = 16'(qz);
        send_item(it);
    endtask

    // Walk through search, capture, follow, hold and the odd item kind
    task automatic test_directed;
        sample_t it;
        it = make_item(OP_TICK, 1'b1);
        it.pos_valid = 1'b0;
        send_item(it);
        it = make_item(OP_TICK, 1'b1);
        it.pos_valid = 1'b1;
        it.north = 32'sh7FFFFFFF;
        it.east = 32'sh80000000;
        it.down = '0;
        send_item(it);
        send_item(make_item(OP_SPARE, 1'b1));
        send_detect(4095, 4095, 16384, 0, 0, 0);
        send_item(make_item(OP_TICK, 1'b1));
        send_detect(0, 0, 16384, 0, 0, 0);
        send_detect(4095, 4095, -16384, 16384, -16384, 16384);
        // zero attitude vector: a and b both vanish
        send_detect(320, 100, -8192, 8192, 8192, 8192);
        send_detect(0, 4095, 0, 0, 0, 16384);
        send_detect(4095, 0, 0, 16384, 16384, 0);
        send_detect(1000, 50, 0, 0, 16384, 0);
        send_item(make_item(OP_LOST, 1'b1));
        send_item(make_item(OP_TICK, 1'b1));
        send_item(make_item(OP_SPARE, 1'b1));
        send_item(make_item(OP_LOST, 1'b1));
        send_item(make_item(OP_TICK, 1'b1));
        send_detect(200, 300, 1000, -2000, 3000, -4000);
        send_item(make_item(OP_TICK, 1'b1));
    endtask

    // Run the miss count past the loss limit and leave follow mode
    task automatic test_miss_limit;
        load_settings(256, 256, 320, 100, 40, -32768, 32767);
        send_item(make_item(OP_DETECT, 1'b1));
        send_item(make_item(OP_TICK, 1'b1));
        repeat (60) send_item(make_item(OP_LOST, 1'b1));
        send_item(make_item(OP_TICK, 1'b1));
        send_item(make_item(OP_TICK, 1'b1));
    endtask

    task automatic test_random(input int count, input logic offboard_only);
        int r;
        logic [1:0] op;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            op = (r < 40) ? OP_TICK : (r < 72) ? OP_DETECT : (r < 97) ? OP_LOST : OP_SPARE;
            send_item(make_item(op, offboard_only ? 1'b1 : ($urandom_range(0, 3) != 0)));
        end
    endtask

    // Hold the receiver off while items keep coming, so the input stalls
    task automatic test_backpressure;
        hold_request = 600;
        repeat (12) send_item(make_item(($urandom_range(0, 1) != 0) ? OP_TICK : OP_DETECT,
            1'b1));
    endtask

    // Pilot takeover: silence once, then quiet ticks for good
    task automatic test_takeover;
        drain();
        send_item(make_item(OP_TICK, 1'b0));
        send_item(make_item(OP_TICK, 1'b0));
        send_item(make_item(OP_DETECT, 1'b1));
        send_item(make_item(OP_TICK, 1'b1));
        test_random(100, 1'b0);
    endtask

    // Receiver side: random stalls plus a long requested hold-off
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare each setpoint with the oldest prediction
    always @(posedge clk)
    begin
        setpoint_t want;
        setpoint_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.heartbeat = m_axis_tdata[0];
            got.hold_n = m_axis_tdata[32:1];
            got.hold_e = m_axis_tdata[64:33];
            got.hold_d = m_axis_tdata[96:65];
            got.vel_n = m_axis_tdata[128:97];
            got.vel_e = m_axis_tdata[160:129];
            got.spin = m_axis_tdata[176:161];
            got.mode = m_axis_tdata[178:177];
            got.kind = m_axis_tuser;
            if (pending_setpoints.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected setpoint: %p", got);
            end
            else
            begin
                want = pending_setpoints.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("setpoint mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles in which nothing moves
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_TICK;
        m_axis_tready = 1'b0;
        mismatches = 0;
        send_idle_pct = 11;
        recv_idle_pct = 86;
        hold_request = 0;
        hold_left = 0;
        quiet_cycles = 0;
        dist_gain = 256;
        yaw_gain = 256;
        img_mid = 320;
        height_goal = 100;
        loss_limit = 20;
        hover_spin = 0;
        search_spin = 2048;
        flight_mode = MODE_SEARCH;
        target_seen = 1'b0;
        miss_count = '0;
        held_n = '0;
        held_e = '0;
        held_d = '0;
        pos_captured = 1'b0;
        takeover_seen = 1'b0;
        output_stopped = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_miss_limit();

        load_settings(0, 0, 1, 1, 0, -32768, -32768);
        test_random(150, 1'b1);
        load_settings(300, 900, 640, 120, 3, 1234, -777);
        test_random(250, 1'b1);
        test_backpressure();

        send_idle_pct = 86;
        recv_idle_pct = 11;
        load_settings(65535, 65535, 4095, 4095, 65535, 32767, 32767);
        test_random(200, 1'b1);
        load_settings(65535, 65535, 1, 1, 1, -1, 1);
        test_random(200, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(512, 128, 320, 100, 5, 400, 2048);
        test_random(300, 1'b1);
        test_takeover();

        drain();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_setpoints.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
